// File: sv/btb_pkg.sv
// ----------------------------------------------------------------------------
// btb_pkg
// Shared constants and types of the branch target buffer predictor.
// ----------------------------------------------------------------------------
package btb_pkg;

  localparam int unsigned HIST_W      = 8;
  localparam int unsigned TAG_W       = 30;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned CNT_W       = 2;
  localparam int unsigned ALIGN_SH    = 2;
  localparam int unsigned SHARE_LSB   = 2;
  localparam int unsigned SHARE_MID   = 16;
  localparam int unsigned DEF_ENTRIES = 32;

  localparam logic [1:0] CMD_PREDICT = 2'd0;
  localparam logic [1:0] CMD_UPDATE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [2:0] REG_BTB_LOG2  = 3'd0;
  localparam logic [2:0] REG_HIST_BITS = 3'd1;
  localparam logic [2:0] REG_TAG_BITS  = 3'd2;
  localparam logic [2:0] REG_INIT      = 3'd3;
  localparam logic [2:0] REG_GLB_HIST  = 3'd4;
  localparam logic [2:0] REG_GLB_TABLE = 3'd5;
  localparam logic [2:0] REG_SHARE     = 3'd6;

  localparam logic [1:0] SHARE_NONE = 2'd0;
  localparam logic [1:0] SHARE_LO   = 2'd1;

  localparam logic [CNT_W-1:0] RST_INIT = 2'd1;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] target;
    logic [HIST_W-1:0] hist;
  } row_t;

endpackage

// File: sv/btb_cnt_ram.sv
// ----------------------------------------------------------------------------
// btb_cnt_ram
// Two-bit counter memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module btb_cnt_ram import btb_pkg::*; #(
  parameter int unsigned AW = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [CNT_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [CNT_W-1:0] rdata
);

  logic [CNT_W-1:0] mem [(1 << AW)];
  logic [CNT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/btb_row_ram.sv
// ----------------------------------------------------------------------------
// btb_row_ram
// Per-row tag, target and history memory with a registered read port.
// ----------------------------------------------------------------------------
module btb_row_ram import btb_pkg::*; #(
  parameter int unsigned AW = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  row_t          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output row_t          rdata
);

  row_t mem [(1 << AW)];
  row_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/btb_branch_predictor.sv
// ----------------------------------------------------------------------------
// btb_branch_predictor
// Branch target buffer with two-bit counters, local or global history and
// counter tables, gshare and lshare indexing.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-----------------------------------------
//   in        | start / busy         | in_cmd in_pc in_target_pc in_taken in_pred_dst
//   out       | out_valid (strobe)   | out_pred_taken out_pred_target
//             |                      | out_mispredicted out_branch_count out_flush_count
//   cfg       | cfg_we               | cfg_addr cfg_wdata
//
// Predict and update pass through row memory read, counter memory read,
// then counter and row write-back. An update that reallocates a row with
// per-row tables first refills the row's counters, one entry a cycle, and
// then reads the counter again. Clear and reset sweep all 2^(row bits + 8)
// counter entries (8192 at default size), with busy high. The result strobe
// lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module btb_branch_predictor import btb_pkg::*; #(
  parameter int unsigned MAX_BTB_ENTRIES = DEF_ENTRIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_cmd,
  input  logic [ADDR_W-1:0] in_pc,
  input  logic [ADDR_W-1:0] in_target_pc,
  input  logic              in_taken,
  input  logic [ADDR_W-1:0] in_pred_dst,
  output logic              out_valid,
  output logic              out_pred_taken,
  output logic [ADDR_W-1:0] out_pred_target,
  output logic              out_mispredicted,
  output logic [31:0]       out_branch_count,
  output logic [31:0]       out_flush_count,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [4:0]        cfg_wdata
);

  localparam int unsigned LOG_MAX = $clog2(MAX_BTB_ENTRIES + 1) - 1;
  localparam int unsigned LOG_CAP = (LOG_MAX > 7) ? 7 : LOG_MAX;
  localparam int unsigned RW      = (LOG_CAP > 0) ? LOG_CAP : 1;
  localparam int unsigned ROWS    = 1 << RW;
  localparam int unsigned CAW     = RW + HIST_W;
  localparam logic [2:0]  LOG_LIM = 3'(LOG_CAP);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROW  = 3'd1;
  localparam logic [2:0] ST_FILL = 3'd2;
  localparam logic [2:0] ST_RDC  = 3'd3;
  localparam logic [2:0] ST_CNT  = 3'd4;
  localparam logic [2:0] ST_CLR  = 3'd5;

  logic [2:0]  cfg_log2_r;
  logic [3:0]  cfg_hist_r;
  logic [4:0]  cfg_tag_r;
  logic [1:0]  cfg_init_r;
  logic        cfg_gh_r;
  logic        cfg_gt_r;
  logic [1:0]  cfg_share_r;

  logic [2:0]        state_r, state_nxt;
  logic [CAW-1:0]    sweep_r, sweep_nxt;
  logic [1:0]        cmd_r;
  logic [ADDR_W-1:0] pc_r, tgt_in_r, pdst_r;
  logic              taken_r;
  logic [RW-1:0]     row_r;
  logic [ROWS-1:0]   valid_r;
  logic [HIST_W-1:0] shist_r;
  logic [31:0]       bcnt_r, fcnt_r;
  logic [CNT_W-1:0]  fill_r;
  logic              hit_r, alloc_r;
  logic [HIST_W-1:0] hist_r, idx_r;
  logic [ADDR_W-1:0] row_tgt_r;

  logic              accept;
  logic [2:0]        eff_log;
  logic [3:0]        eff_hist;
  logic [4:0]        eff_tag;
  logic [ADDR_W-1:0] row_mask, in_row_full, tag_shift, tag_mask, tag_full;
  logic [RW-1:0]     in_row;
  logic [TAG_W-1:0]  tag_cur;
  logic [8:0]        hmask9;
  logic [HIST_W-1:0] hmask;
  row_t              row_rd, row_wr;
  logic              vld_cur, hit_cur, alloc_cur, fill_req;
  logic [HIST_W-1:0] hist_cur, hsel, share_bits, idx_cur, hbase, hist_new;
  logic [CNT_W-1:0]  en_rdata, sh_rdata, cnt_cur, cnt_new;
  logic              en_we, en_re, sh_we, sh_re, row_we;
  logic [CAW-1:0]    en_waddr, en_raddr;
  logic [HIST_W-1:0] sh_waddr;
  logic [CNT_W-1:0]  en_wdata, sh_wdata;
  logic              is_upd, mis_cur, ptaken_cur;
  logic [ADDR_W-1:0] pc_plus4;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  assign eff_log  = (cfg_log2_r > LOG_LIM) ? LOG_LIM : cfg_log2_r;
  assign eff_hist = (cfg_hist_r == 4'd0) ? 4'd1 :
                    (cfg_hist_r > 4'(HIST_W)) ? 4'(HIST_W) : cfg_hist_r;
  assign eff_tag  = (cfg_tag_r > 5'd30) ? 5'd30 : cfg_tag_r;

  assign row_mask    = (32'd1 << eff_log) - 32'd1;
  assign in_row_full = (in_pc >> ALIGN_SH) & row_mask;
  assign in_row      = in_row_full[RW-1:0];
  assign tag_shift   = pc_r >> (6'(ALIGN_SH) + 6'(eff_log));
  assign tag_mask    = (32'd1 << eff_tag) - 32'd1;
  assign tag_full    = tag_shift & tag_mask;
  assign tag_cur     = tag_full[TAG_W-1:0];
  assign hmask9      = (9'd1 << eff_hist) - 9'd1;
  assign hmask       = hmask9[HIST_W-1:0];

  assign vld_cur   = valid_r[row_r];
  assign hist_cur  = vld_cur ? row_rd.hist : '0;
  assign hit_cur   = vld_cur && (row_rd.tag == tag_cur);
  assign alloc_cur = (cmd_r == CMD_UPDATE) && !hit_cur;
  assign fill_req  = alloc_cur && !cfg_gt_r;
  assign hsel      = cfg_gh_r ? shist_r : (alloc_cur ? '0 : hist_cur);
  assign share_bits = (cfg_share_r == SHARE_LO) ? pc_r[SHARE_LSB +: HIST_W]
                                                : pc_r[SHARE_MID +: HIST_W];
  always_comb begin
    idx_cur = hsel & hmask;
    if (cfg_gt_r && cfg_share_r != SHARE_NONE) begin
      idx_cur = idx_cur ^ (share_bits & hmask);
    end
  end

  assign is_upd     = (cmd_r == CMD_UPDATE);
  assign pc_plus4   = pc_r + 32'd4;
  assign cnt_cur    = cfg_gt_r ? sh_rdata : en_rdata;
  assign ptaken_cur = hit_r && (cnt_cur >= 2'd2);
  assign mis_cur    = taken_r ? (tgt_in_r != pdst_r) : (pc_plus4 != pdst_r);
  assign cnt_new    = (taken_r && cnt_cur != 2'd3) ? cnt_cur + 2'd1 :
                      (!taken_r && cnt_cur != 2'd0) ? cnt_cur - 2'd1 : cnt_cur;
  assign hbase      = cfg_gh_r ? shist_r : (alloc_r ? '0 : hist_r);
  assign hist_new   = {hbase[HIST_W-2:0], taken_r} & hmask;

  assign row_we        = (state_r == ST_CNT) && is_upd;
  assign row_wr.tag    = tag_cur;
  assign row_wr.target = tgt_in_r;
  assign row_wr.hist   = cfg_gh_r ? hist_r : hist_new;

  always_comb begin
    en_we    = 1'b0;
    en_waddr = {row_r, idx_r};
    en_wdata = fill_r;
    sh_we    = 1'b0;
    sh_waddr = idx_r;
    sh_wdata = cnt_new;
    case (state_r)
      ST_CLR: begin
        en_we    = 1'b1;
        en_waddr = sweep_r;
        sh_we    = 1'b1;
        sh_waddr = sweep_r[HIST_W-1:0];
        sh_wdata = fill_r;
      end
      ST_FILL: begin
        en_we    = 1'b1;
        en_waddr = {row_r, sweep_r[HIST_W-1:0]};
      end
      ST_CNT: begin
        en_we    = is_upd && !cfg_gt_r;
        en_wdata = cnt_new;
        sh_we    = is_upd && cfg_gt_r;
      end
      default: begin
        en_we = 1'b0;
      end
    endcase
  end

  assign en_re    = ((state_r == ST_ROW) && !fill_req) || (state_r == ST_RDC);
  assign sh_re    = en_re;
  assign en_raddr = (state_r == ST_ROW) ? {row_r, idx_cur} : {row_r, idx_r};

  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_PREDICT || in_cmd == CMD_UPDATE) begin
            state_nxt = ST_ROW;
          end else if (in_cmd == CMD_CLEAR) begin
            state_nxt = ST_CLR;
            sweep_nxt = '0;
          end
        end
      end
      ST_ROW: begin
        sweep_nxt = '0;
        state_nxt = fill_req ? ST_FILL : ST_CNT;
      end
      ST_FILL: begin
        sweep_nxt = sweep_r + 1'b1;
        if (&sweep_r[HIST_W-1:0]) begin
          state_nxt = ST_RDC;
        end
      end
      ST_RDC: state_nxt = ST_CNT;
      ST_CNT: state_nxt = ST_IDLE;
      ST_CLR: begin
        sweep_nxt = sweep_r + 1'b1;
        if (&sweep_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_log2_r  <= 3'd5;
      cfg_hist_r  <= 4'd8;
      cfg_tag_r   <= 5'd0;
      cfg_init_r  <= RST_INIT;
      cfg_gh_r    <= 1'b0;
      cfg_gt_r    <= 1'b0;
      cfg_share_r <= SHARE_NONE;
      state_r     <= ST_CLR;
      sweep_r     <= '0;
      fill_r      <= RST_INIT;
      valid_r     <= '0;
      shist_r     <= '0;
      bcnt_r      <= '0;
      fcnt_r      <= '0;
      out_valid   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sweep_r   <= sweep_nxt;
      out_valid <= (accept && in_cmd != CMD_PREDICT && in_cmd != CMD_UPDATE) ||
                   (state_r == ST_CNT);
      if (cfg_we) begin
        case (cfg_addr)
          REG_BTB_LOG2:  cfg_log2_r  <= cfg_wdata[2:0];
          REG_HIST_BITS: cfg_hist_r  <= cfg_wdata[3:0];
          REG_TAG_BITS:  cfg_tag_r   <= cfg_wdata;
          REG_INIT:      cfg_init_r  <= cfg_wdata[1:0];
          REG_GLB_HIST:  cfg_gh_r    <= cfg_wdata[0];
          REG_GLB_TABLE: cfg_gt_r    <= cfg_wdata[0];
          REG_SHARE:     cfg_share_r <= cfg_wdata[1:0];
          default:       cfg_gt_r    <= cfg_gt_r;
        endcase
      end
      if (accept && in_cmd == CMD_CLEAR) begin
        fill_r    <= cfg_init_r;
        valid_r   <= '0;
        shist_r   <= '0;
        bcnt_r    <= '0;
        fcnt_r    <= '0;
      end
      if (state_r == ST_ROW) begin
        fill_r <= cfg_init_r;
      end
      if (row_we) begin
        valid_r[row_r] <= 1'b1;
        bcnt_r         <= bcnt_r + 32'd1;
        if (mis_cur) begin
          fcnt_r <= fcnt_r + 32'd1;
        end
        if (cfg_gh_r) begin
          shist_r <= hist_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd;
      pc_r     <= in_pc;
      tgt_in_r <= in_target_pc;
      taken_r  <= in_taken;
      pdst_r   <= in_pred_dst;
      row_r    <= in_row;
      out_pred_taken   <= 1'b0;
      out_pred_target  <= '0;
      out_mispredicted <= 1'b0;
      out_branch_count <= (in_cmd == CMD_CLEAR) ? 32'd0 : bcnt_r;
      out_flush_count  <= (in_cmd == CMD_CLEAR) ? 32'd0 : fcnt_r;
    end
    if (state_r == ST_ROW) begin
      hit_r     <= hit_cur;
      alloc_r   <= alloc_cur;
      hist_r    <= hist_cur;
      idx_r     <= idx_cur;
      row_tgt_r <= row_rd.target;
    end
    if (state_r == ST_CNT) begin
      out_pred_taken   <= !is_upd && ptaken_cur;
      out_pred_target  <= is_upd ? '0 : (ptaken_cur ? row_tgt_r : pc_plus4);
      out_mispredicted <= is_upd && mis_cur;
      out_branch_count <= is_upd ? bcnt_r + 32'd1 : bcnt_r;
      out_flush_count  <= (is_upd && mis_cur) ? fcnt_r + 32'd1 : fcnt_r;
    end
  end

  btb_row_ram #(.AW(RW)) u_row (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_r),
    .wdata (row_wr),
    .re    (accept),
    .raddr (in_row),
    .rdata (row_rd)
  );

  btb_cnt_ram #(.AW(CAW)) u_entry_cnt (
    .clk   (clk),
    .we    (en_we),
    .waddr (en_waddr),
    .wdata (en_wdata),
    .re    (en_re),
    .raddr (en_raddr),
    .rdata (en_rdata)
  );

  btb_cnt_ram #(.AW(HIST_W)) u_shared_cnt (
    .clk   (clk),
    .we    (sh_we),
    .waddr (sh_waddr),
    .wdata (sh_wdata),
    .re    (sh_re),
    .raddr (en_raddr[HIST_W-1:0]),
    .rdata (sh_rdata)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == CMD_PREDICT || in_cmd == CMD_UPDATE)) |=> busy)
    else $error("predict or update did not start work");
  a_row_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROW) |=> (state_r == ST_CNT || state_r == ST_FILL))
    else $error("row stage went to an unexpected state");
  a_cnt_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CNT) |=> out_valid)
    else $error("counter stage gave no result");
  a_fill_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> (alloc_r && !cfg_gt_r))
    else $error("row refill without allocation");
`endif

endmodule

// File: bench/btb_branch_predictor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// btb_branch_predictor_checker
// Watches the command, result and register write ports of the branch target
// buffer. Keeps its own copy of registers, rows, histories and counters,
// computes the result of every accepted command and compares it field by
// field with the strobed result.
// ----------------------------------------------------------------------------
module btb_branch_predictor_checker import btb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_cmd,
  input  logic [ADDR_W-1:0] in_pc,
  input  logic [ADDR_W-1:0] in_target_pc,
  input  logic              in_taken,
  input  logic [ADDR_W-1:0] in_pred_dst,
  input  logic              out_valid,
  input  logic              out_pred_taken,
  input  logic [ADDR_W-1:0] out_pred_target,
  input  logic              out_mispredicted,
  input  logic [31:0]       out_branch_count,
  input  logic [31:0]       out_flush_count,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [4:0]        cfg_wdata,
  input  logic              done,
  output int                fail_count
);

  typedef struct packed {
    logic              pred_taken;
    logic [ADDR_W-1:0] pred_target;
    logic              mispredicted;
    logic [31:0]       branch_count;
    logic [31:0]       flush_count;
  } btb_result_t;

  localparam int unsigned ROWS = 32;
  localparam int unsigned TBL  = 256;

  logic [2:0] r_log2;
  logic [3:0] r_hist;
  logic [4:0] r_tag;
  logic [1:0] r_init;
  logic       r_ghist;
  logic       r_gtbl;
  logic [1:0] r_share;

  logic [TAG_W-1:0]  row_tag    [ROWS];
  logic [ADDR_W-1:0] row_target [ROWS];
  logic              row_valid  [ROWS];
  logic [HIST_W-1:0] row_hist   [ROWS];
  logic [1:0]        row_ctr    [ROWS][TBL];
  logic [1:0]        glb_ctr    [TBL];
  logic [HIST_W-1:0] glb_hist;
  logic [31:0]       branches;
  logic [31:0]       flushes;

  btb_result_t expected_results[$];
  int          mismatches;

  function automatic int unsigned rows_log2();
    int unsigned l;
    l = r_log2;
    while (l > 0 && (1 << l) > ROWS) l--;
    return l;
  endfunction

  function automatic int unsigned hist_len();
    int unsigned h;
    h = r_hist;
    if (h < 1) h = 1;
    if (h > HIST_W) h = HIST_W;
    return h;
  endfunction

  // index into the selected counter table, shared table or the row's own
  function automatic int unsigned ctr_index(logic [31:0] pc, int unsigned row);
    logic [31:0] mask;
    logic [31:0] idx;
    mask = (32'd1 << hist_len()) - 1;
    idx  = (r_ghist ? glb_hist : row_hist[row]) & mask;
    if (r_gtbl && r_share != SHARE_NONE)
      idx ^= (pc >> ((r_share == SHARE_LO) ? SHARE_LSB : SHARE_MID)) & mask;
    return idx & (TBL - 1);
  endfunction

  task automatic wipe_state();
    for (int r = 0; r < ROWS; r++) begin
      row_tag[r]    = '0;
      row_target[r] = '0;
      row_valid[r]  = 1'b0;
      row_hist[r]   = '0;
      for (int i = 0; i < TBL; i++) row_ctr[r][i] = r_init;
    end
    for (int i = 0; i < TBL; i++) glb_ctr[i] = r_init;
    glb_hist = '0;
    branches = '0;
    flushes  = '0;
  endtask

  task automatic predict_command();
    int unsigned row;
    int unsigned idx;
    int unsigned l;
    int unsigned t;
    logic [31:0] tag;
    logic [31:0] mask;
    logic [1:0]  c;
    btb_result_t res;
    res  = '0;
    l    = rows_log2();
    row  = (in_pc >> ALIGN_SH) & ((32'd1 << l) - 1);
    t    = (r_tag > TAG_W) ? TAG_W : r_tag;
    tag  = (in_pc >> (ALIGN_SH + l)) & ((32'd1 << t) - 1);
    mask = (32'd1 << hist_len()) - 1;
    case (in_cmd)
      CMD_PREDICT: begin
        idx = ctr_index(in_pc, row);
        c   = r_gtbl ? glb_ctr[idx] : row_ctr[row][idx];
        if (row_valid[row] && row_tag[row] == tag[TAG_W-1:0] && c >= 2) begin
          res.pred_taken  = 1'b1;
          res.pred_target = row_target[row];
        end else begin
          res.pred_target = in_pc + 32'd4;
        end
      end
      CMD_UPDATE: begin
        branches++;
        if ((in_taken && in_target_pc != in_pred_dst) ||
            (!in_taken && in_pc + 32'd4 != in_pred_dst)) begin
          flushes++;
          res.mispredicted = 1'b1;
        end
        row_target[row] = in_target_pc;
        if (!row_valid[row] || row_tag[row] != tag[TAG_W-1:0]) begin
          row_valid[row] = 1'b1;
          row_tag[row]   = tag[TAG_W-1:0];
          if (!r_ghist) row_hist[row] = '0;
          if (!r_gtbl) for (int i = 0; i < TBL; i++) row_ctr[row][i] = r_init;
        end
        idx = ctr_index(in_pc, row);
        c   = r_gtbl ? glb_ctr[idx] : row_ctr[row][idx];
        if (in_taken && c < 3) c++;
        else if (!in_taken && c > 0) c--;
        if (r_gtbl) glb_ctr[idx] = c;
        else row_ctr[row][idx] = c;
        if (r_ghist) glb_hist = HIST_W'(((glb_hist << 1) | in_taken) & mask);
        else row_hist[row] = HIST_W'(((row_hist[row] << 1) | in_taken) & mask);
      end
      CMD_CLEAR: wipe_state();
      default: ;
    endcase
    res.branch_count = branches;
    res.flush_count  = flushes;
    expected_results.push_back(res);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      r_log2  <= 3'd5;
      r_hist  <= 4'd8;
      r_tag   <= 5'd0;
      r_init  <= RST_INIT;
      r_ghist <= 1'b0;
      r_gtbl  <= 1'b0;
      r_share <= SHARE_NONE;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BTB_LOG2:  r_log2  <= cfg_wdata[2:0];
        REG_HIST_BITS: r_hist  <= cfg_wdata[3:0];
        REG_TAG_BITS:  r_tag   <= cfg_wdata[4:0];
        REG_INIT:      r_init  <= cfg_wdata[1:0];
        REG_GLB_HIST:  r_ghist <= cfg_wdata[0];
        REG_GLB_TABLE: r_gtbl  <= cfg_wdata[0];
        REG_SHARE:     r_share <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    btb_result_t exp_r;
    if (!rst_n) begin
      wipe_state();
      expected_results.delete();
      mismatches = 0;
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result with no transaction pending", $realtime);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.pred_taken !== out_pred_taken || exp_r.pred_target !== out_pred_target ||
              exp_r.mispredicted !== out_mispredicted ||
              exp_r.branch_count !== out_branch_count ||
              exp_r.flush_count !== out_flush_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch exp taken=%0b tgt=%h mis=%0b br=%0d fl=%0d",
                        " got taken=%0b tgt=%h mis=%0b br=%0d fl=%0d"},
                       $realtime, exp_r.pred_taken, exp_r.pred_target, exp_r.mispredicted,
                       exp_r.branch_count, exp_r.flush_count, out_pred_taken,
                       out_pred_target, out_mispredicted, out_branch_count, out_flush_count);
          end
        end
      end
      if (start && !busy) predict_command();
      fail_count <= mismatches + (done ? expected_results.size() : 0);
    end
  end

endmodule

// File: bench/tb_btb_branch_predictor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_btb_branch_predictor
// Drives the branch target buffer through directed and random predict,
// update, clear and unused commands under many register settings, with
// random idle cycles; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_btb_branch_predictor;
  import btb_pkg::*;

  localparam logic [1:0] CMD_NOP   = 2'd3;
  localparam int         CYCLE_CAP = 25000000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_cmd = CMD_PREDICT;
  logic [ADDR_W-1:0] in_pc = '0;
  logic [ADDR_W-1:0] in_target_pc = '0;
  logic              in_taken = 1'b0;
  logic [ADDR_W-1:0] in_pred_dst = '0;
  logic              out_valid;
  logic              out_pred_taken;
  logic [ADDR_W-1:0] out_pred_target;
  logic              out_mispredicted;
  logic [31:0]       out_branch_count;
  logic [31:0]       out_flush_count;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_addr = REG_BTB_LOG2;
  logic [4:0]        cfg_wdata = '0;
  logic              done = 1'b0;
  int                fail_count;

  int          cycles = 0;
  int          sent = 0;
  int          received = 0;
  logic        quiet = 1'b0;
  logic [31:0] pc_pool [8];
  logic [31:0] tgt_pool [8];

  always #5 clk = ~clk;

  btb_branch_predictor DUT (.*);

  btb_branch_predictor_checker u_checker (.*);

  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_valid) received++;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL btb_branch_predictor");
      $finish;
    end
  end

  task automatic issue(logic [1:0] cmd, logic [31:0] pc, logic [31:0] tgt, logic tk,
                       logic [31:0] pdst);
    while (!quiet && $urandom_range(99) < 14) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_cmd       <= cmd;
    in_pc        <= pc;
    in_target_pc <= tgt;
    in_taken     <= tk;
    in_pred_dst  <= pdst;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (received != sent || busy) @(posedge clk);
  endtask

  task automatic set_regs(logic [4:0] v [7]);
    drain();
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= i[2:0];
      cfg_wdata <= v[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item();
    int          k;
    int          r;
    logic [1:0]  cmd;
    logic [31:0] pc;
    logic [31:0] tgt;
    logic        tk;
    logic [31:0] pdst;
    k   = $urandom_range(7);
    pc  = ($urandom_range(99) < 80) ? pc_pool[k] : $urandom();
    tgt = ($urandom_range(99) < 85) ? tgt_pool[k] : $urandom();
    tk  = ($urandom_range(3) != 0) ^ (k > 5);
    r   = $urandom_range(99);
    if (r < 45) cmd = CMD_PREDICT;
    else if (r < 95) cmd = CMD_UPDATE;
    else if (r < 97) cmd = CMD_CLEAR;
    else cmd = CMD_NOP;
    if ($urandom_range(99) < 75) pdst = tk ? tgt : pc + 32'd4;
    else pdst = $urandom();
    issue(cmd, pc, tgt, tk, pdst);
  endtask

  initial begin
    logic [4:0] regs [7];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    drain();

    issue(CMD_PREDICT, 32'h0, 32'h0, 1'b0, 32'h0);
    issue(CMD_UPDATE, 32'h0, 32'hffff_ffff, 1'b1, 32'hffff_ffff);
    issue(CMD_PREDICT, 32'h0, 32'h0, 1'b0, 32'h0);
    issue(CMD_UPDATE, 32'h0, 32'hffff_ffff, 1'b1, 32'hffff_ffff);
    issue(CMD_UPDATE, 32'h0, 32'hffff_ffff, 1'b1, 32'h1234_5678);
    issue(CMD_PREDICT, 32'h0, 32'h0, 1'b0, 32'h0);
    issue(CMD_UPDATE, 32'hffff_ffff, 32'h0, 1'b0, 32'h0000_0003);
    issue(CMD_UPDATE, 32'hffff_fffc, 32'h0, 1'b0, 32'h0);
    issue(CMD_PREDICT, 32'hffff_ffff, 32'h0, 1'b0, 32'h0);
    issue(CMD_NOP, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'hffff_ffff);
    issue(CMD_CLEAR, 32'h0, 32'h0, 1'b0, 32'h0);
    issue(CMD_PREDICT, 32'h0, 32'h0, 1'b0, 32'h0);

    regs = '{5'd7, 5'd15, 5'd31, 5'd3, 5'd1, 5'd1, 5'd3};
    set_regs(regs);
    issue(CMD_CLEAR, 32'h0, 32'h0, 1'b0, 32'h0);
    issue(CMD_UPDATE, 32'h8001_0004, 32'haaaa_aaa8, 1'b1, 32'haaaa_aaa8);
    issue(CMD_PREDICT, 32'h8001_0004, 32'h0, 1'b0, 32'h0);
    issue(CMD_PREDICT, 32'h4001_0004, 32'h0, 1'b0, 32'h0);
    issue(CMD_UPDATE, 32'h4001_0004, 32'h5555_5554, 1'b0, 32'h4001_0008);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: regs = '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
        1: regs = '{5'd5, 5'd8, 5'd30, 5'd2, 5'd0, 5'd1, 5'd1};
        2: regs = '{5'd2, 5'd3, 5'd4, 5'd1, 5'd1, 5'd0, 5'd2};
        3: regs = '{5'd3, 5'd1, 5'd12, 5'd0, 5'd1, 5'd1, 5'd0};
        4: regs = '{5'd6, 5'd9, 5'd20, 5'd3, 5'd0, 5'd0, 5'd1};
        5: regs = '{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31};
        default: for (int i = 0; i < 7; i++) regs[i] = 5'($urandom_range(31));
      endcase
      set_regs(regs);
      for (int i = 0; i < 8; i++) begin
        pc_pool[i]  = $urandom();
        tgt_pool[i] = $urandom();
      end
      quiet = (ph == 3);
      if ($urandom_range(1)) issue(CMD_CLEAR, 32'h0, 32'h0, 1'b0, 32'h0);
      for (int n = 0; n < 53; n++) random_item();
    end

    drain();
    repeat (300) @(posedge clk);
    done <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS btb_branch_predictor");
    end else begin
      $display("FAIL btb_branch_predictor");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/btb_pkg.sv
sv/btb_cnt_ram.sv
sv/btb_row_ram.sv
sv/btb_branch_predictor.sv
bench/btb_branch_predictor_checker.sv
bench/tb_btb_branch_predictor.sv
